// File: design/hsip_pkg.sv
`timescale 1ns / 1ps

package hsip_pkg;

  localparam int unsigned COMPRESS_ROUNDS_DEF = 2;
  localparam int unsigned FINAL_ROUNDS_DEF    = 4;

  localparam logic [31:0] INIT_C     = 32'h6c796765;
  localparam logic [31:0] INIT_D     = 32'h74656462;
  localparam logic [31:0] FINAL_FLIP = 32'h000000ff;
  localparam int unsigned LEN_LSB    = 24;

  localparam logic [2:0] FULL_BYTES = 3'd4;

  // Configuration register indexes.
  localparam logic REG_KEY_LOW  = 1'b0;
  localparam logic REG_KEY_HIGH = 1'b1;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } lanes_t;

  // Commands from the controller to the datapath for one cycle.
  typedef struct packed {
    logic start;     // accept an input transaction
    logic round;     // run one round on the lanes
    logic pre;       // xor the message word into lane d before the round
    logic post;      // xor the message word into lane a after the round
    logic use_fin;   // message word is the final length word
    logic flip;      // xor 0xff into lane c before the round
    logic load_out;  // capture the hash into the output register
    logic close;     // the message ends this cycle
  } cmd_t;

  typedef struct packed {
    logic out_free;   // output register can take a new hash this cycle
    logic item_full;  // incoming item carries a full word to compress
  } status_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned r);
    rotl = (x << r) | (x >> (32 - r));
  endfunction

  function automatic lanes_t sip_round(input lanes_t v);
    lanes_t r;
    r = v;
    r.a = r.a + r.b;
    r.b = rotl(r.b, 5) ^ r.a;
    r.a = rotl(r.a, 16);
    r.c = r.c + r.d;
    r.d = rotl(r.d, 8) ^ r.c;
    r.a = r.a + r.d;
    r.d = rotl(r.d, 7) ^ r.a;
    r.c = r.c + r.b;
    r.b = rotl(r.b, 13) ^ r.c;
    r.c = rotl(r.c, 16);
    sip_round = r;
  endfunction

endpackage

// File: design/hsip_ctrl.sv
`timescale 1ns / 1ps

module hsip_ctrl
  import hsip_pkg::*;
#(
  parameter int unsigned COMPRESS_ROUNDS = COMPRESS_ROUNDS_DEF,
  parameter int unsigned FINAL_ROUNDS    = FINAL_ROUNDS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    last,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  localparam int unsigned MAX_ROUNDS =
    (COMPRESS_ROUNDS > FINAL_ROUNDS) ? COMPRESS_ROUNDS : FINAL_ROUNDS;
  localparam int unsigned CNT_W = $clog2(MAX_ROUNDS + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_COMP  = 3'b010,
    ST_FINAL = 3'b100
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             fin_phase, fin_phase_next;
  logic             pend_fin, pend_fin_next;
  logic             comp_done;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    cmd            = '0;
    state_next     = state;
    cnt_next       = cnt;
    fin_phase_next = fin_phase;
    pend_fin_next  = pend_fin;
    comp_done      = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          // The first compression round runs in the cycle the item is taken.
          cmd.start      = 1'b1;
          cmd.round      = 1'b1;
          cmd.pre        = 1'b1;
          cmd.post       = (COMPRESS_ROUNDS == 1);
          fin_phase_next = last && !status.item_full;
          pend_fin_next  = last && status.item_full;
          cnt_next       = CNT_W'(1);
          comp_done      = (COMPRESS_ROUNDS == 1);
          state_next     = ST_COMP;
        end
      end
      ST_COMP: begin
        cmd.round   = 1'b1;
        cmd.pre     = (cnt == '0);
        cmd.post    = (cnt == CNT_W'(COMPRESS_ROUNDS - 1));
        cmd.use_fin = fin_phase;
        cnt_next    = CNT_W'(cnt + 1'b1);
        comp_done   = cmd.post;
      end
      ST_FINAL: begin
        cmd.flip = (cnt == '0);
        if (cnt == CNT_W'(FINAL_ROUNDS - 1)) begin
          // The last round waits until the output register can take the hash.
          if (status.out_free) begin
            cmd.round    = 1'b1;
            cmd.load_out = 1'b1;
            cmd.close    = 1'b1;
            state_next   = ST_IDLE;
          end
        end else begin
          cmd.round = 1'b1;
          cnt_next  = CNT_W'(cnt + 1'b1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (comp_done) begin
      if (fin_phase_next) begin
        state_next = ST_FINAL;
        cnt_next   = '0;
      end else if (pend_fin_next) begin
        state_next     = ST_COMP;
        fin_phase_next = 1'b1;
        pend_fin_next  = 1'b0;
        cnt_next       = '0;
      end else begin
        state_next = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      fin_phase <= 1'b0;
      pend_fin  <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      fin_phase <= fin_phase_next;
      pend_fin  <= pend_fin_next;
    end
  end

endmodule

// File: design/hsip_dp.sv
`timescale 1ns / 1ps

module hsip_dp
  import hsip_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [31:0] wr_data,
  input  logic [31:0] word,
  input  logic [2:0]  byte_count,
  input  logic        last,
  output logic [31:0] hash,
  output logic        out_valid,
  input  logic        out_stall,
  input  cmd_t        cmd,
  output status_t     status
);

  logic [31:0] key_low, key_high;
  lanes_t      lanes, lanes_in, lanes_out, seed;
  logic [7:0]  length, len_base, len_new;
  logic        msg_open;
  logic [31:0] m_reg, fin_reg;
  logic [31:0] m_comb, fin_comb, msg;
  logic [23:0] tail_mask;
  logic        full;

  assign full = !last || (byte_count >= FULL_BYTES);

  always_comb begin
    unique case (byte_count[1:0])
      2'd0:    tail_mask = 24'h000000;
      2'd1:    tail_mask = 24'h0000ff;
      2'd2:    tail_mask = 24'h00ffff;
      2'd3:    tail_mask = 24'hffffff;
      default: tail_mask = 24'h000000;
    endcase
  end

  // A new message starts its length count from zero.
  assign len_base = msg_open ? length : 8'd0;
  assign len_new  = len_base + (full ? {5'd0, FULL_BYTES} : {5'd0, byte_count});
  assign fin_comb = {len_new, (full ? 24'd0 : (word[LEN_LSB-1:0] & tail_mask))};
  assign m_comb   = full ? word : fin_comb;

  assign msg = cmd.start ? m_comb : (cmd.use_fin ? fin_reg : m_reg);

  assign seed.a = key_low;
  assign seed.b = key_high;
  assign seed.c = INIT_C ^ key_low;
  assign seed.d = INIT_D ^ key_high;

  always_comb begin
    lanes_in = (cmd.start && !msg_open) ? seed : lanes;
    if (cmd.pre) begin
      lanes_in.d = lanes_in.d ^ msg;
    end
    if (cmd.flip) begin
      lanes_in.c = lanes_in.c ^ FINAL_FLIP;
    end
    lanes_out = sip_round(lanes_in);
    if (cmd.post) begin
      lanes_out.a = lanes_out.a ^ msg;
    end
  end

  assign status.out_free  = !out_valid || !out_stall;
  assign status.item_full = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low   <= '0;
      key_high  <= '0;
      length    <= '0;
      msg_open  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          REG_KEY_LOW:  key_low  <= wr_data;
          REG_KEY_HIGH: key_high <= wr_data;
          default:      key_low  <= key_low;
        endcase
      end
      if (cmd.start) begin
        length   <= len_new;
        msg_open <= 1'b1;
      end else if (cmd.close) begin
        msg_open <= 1'b0;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      m_reg   <= m_comb;
      fin_reg <= fin_comb;
    end
    if (cmd.round) begin
      lanes <= lanes_out;
    end
    if (cmd.load_out) begin
      hash <= lanes_out.b ^ lanes_out.d;
    end
  end

endmodule

// File: design/halfsiphash_2_4_32.sv
`timescale 1ns / 1ps

// Keyed HalfSipHash with a 32-bit result. A message arrives as little-endian
// 32-bit words, one per transaction; the key is written beforehand through
// the write port (index 0 low word, index 1 high word) and is picked up when
// a message opens. One round unit does one round per cycle, and the first
// compression round runs in the cycle the word is accepted; a word that is
// not last gets COMPRESS_ROUNDS rounds. The last item gets COMPRESS_ROUNDS
// rounds for its length word, COMPRESS_ROUNDS more if it carries four bytes,
// and FINAL_ROUNDS rounds of finalization. The hash sits in an output
// register, so the next message can start while it waits; the last round of
// a later hash holds until that register is free or is being read.
module halfsiphash_2_4_32
  import hsip_pkg::*;
#(
  parameter int unsigned COMPRESS_ROUNDS = COMPRESS_ROUNDS_DEF,
  parameter int unsigned FINAL_ROUNDS    = FINAL_ROUNDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [31:0] wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] word,
  input  logic [2:0]  byte_count,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] hash
);

  cmd_t    cmd;
  status_t status;

  hsip_ctrl #(
    .COMPRESS_ROUNDS (COMPRESS_ROUNDS),
    .FINAL_ROUNDS    (FINAL_ROUNDS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .last     (last),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  hsip_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .word       (word),
    .byte_count (byte_count),
    .last       (last),
    .hash       (hash),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cmd        (cmd),
    .status     (status)
  );

endmodule
